FILE: sv/dsc_pkg.sv
// shared types and codes for the diophantine solution counter
// used by the sequencer top level and the iterative divide/multiply unit
package dsc_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned CNT_W   = 33;
  localparam int unsigned IN_W    = 224;
  localparam int unsigned OUT_W   = 200;

  // unit operation codes
  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  // control group from the sequencer to the shared unit
  typedef struct packed {
    logic start;
    logic op;
    logic len_full;  // 1: 64 iterations, 0: 32 iterations
  } dsc_ctl_t;

endpackage

FILE: sv/diophantine_solution_counter.sv
// Counts integer solutions of a*x + b*y = c inside an x/y box.
//
// Input channel in_*: one transaction carries a, b, c and the four inclusive
// bounds. Result channel out_*: one transaction per input with the count,
// solvable and degenerate flags, a particular solution and the gcd.
// Division truncates toward zero; products and sums wrap at 64 bits.
// A zero coefficient raises degenerate and forces the count to zero.
//
// One item is worked at a time. All divides and multiplies go through one
// shared bit-serial unit (dsc_iter_unit), one bit per cycle, 32 or 64
// iterations per operation. Each Euclid step costs one 32-bit divide and
// two 32-bit multiplies; a 32-bit input needs at most about 46 steps. The
// box search adds four 64-bit divides, up to eight lattice steps (two
// multiplies each) and a final divide.
// in_tready is high only while the sequencer is idle.
//
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid. A stalled receiver holds the result in the output register;
// the next item may be accepted meanwhile, and its result waits at the end
// of its work until the register is free.
module diophantine_solution_counter import dsc_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // coef_a[31:0], coef_b[63:32], rhs_c[95:64], x_lower[127:96],
  // x_upper[159:128], y_lower[191:160], y_upper[223:192]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // solution_count[32:0], solvable[33], degenerate[34], any_x[98:35],
  // any_y[162:99], gcd_value[194:163], zero fill[199:195]
  output logic [OUT_W-1:0] out_tdata
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_WAIT = 5'd1,  S_EU_CHK = 5'd2,
                         S_EU_Q = 5'd3,  S_EU_X = 5'd4,  S_EU_Y   = 5'd5,
                         S_EU_END = 5'd6, S_SOLV = 5'd7, S_X0 = 5'd8,
                         S_Y0 = 5'd9,  S_CA = 5'd10, S_CB = 5'd11,
                         S_ST0 = 5'd12, S_ST1 = 5'd13, S_ST2 = 5'd14,
                         S_B1 = 5'd15, S_B1K = 5'd16, S_B1C = 5'd17,
                         S_B1D = 5'd18, S_B2K = 5'd19, S_B2C = 5'd20,
                         S_B2D = 5'd21, S_B3K = 5'd22, S_B3C = 5'd23,
                         S_B3D = 5'd24, S_B4K = 5'd25, S_B4C = 5'd26,
                         S_B4D = 5'd27, S_B5 = 5'd28, S_CNT = 5'd29,
                         S_FIN = 5'd30;

  localparam logic [WORD_W-1:0] ONE = 64'sd1;

  typedef logic [WORD_W-1:0] word_t;

  function automatic word_t sext_field(input logic [FIELD_W-1:0] raw);
    word_t v;
    v = {{(WORD_W-OPERAND_WIDTH){raw[OPERAND_WIDTH-1]}}, raw[OPERAND_WIDTH-1:0]};
    return v;
  endfunction

  function automatic word_t mag(input word_t v);
    return v[WORD_W-1] ? (~v + ONE) : v;
  endfunction

  function automatic word_t cneg(input word_t v, input logic f);
    return f ? (~v + ONE) : v;
  endfunction

  logic [4:0] state_r, state_nxt, ret_r, ret_nxt, sret_r, sret_nxt;
  word_t a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  word_t minx_r, minx_nxt, maxx_r, maxx_nxt, miny_r, miny_nxt, maxy_r, maxy_nxt;
  word_t eq_r, eq_nxt, ep_r, ep_nxt;
  word_t xq_r, xq_nxt, yq_r, yq_nxt, xp_r, xp_nxt, yp_r, yp_nxt;
  word_t k_r, k_nxt, ca_r, ca_nxt, cb_r, cb_nxt;
  word_t lx1_r, lx1_nxt, rx1_r, rx1_nxt, lx2_r, lx2_nxt;
  logic  dneg_r, dneg_nxt, solv_r, solv_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  dsc_ctl_t uctl;
  word_t    u_a, u_b, u_quot, u_rem, u_prod, sq, lo2, hi2;
  logic     u_done, degen, in_fire;

  dsc_iter_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (uctl),
    .opa   (u_a),
    .opb   (u_b),
    .done  (u_done),
    .quot  (u_quot),
    .rem   (u_rem),
    .prod  (u_prod)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign degen     = (a_r == '0) || (b_r == '0);
  assign sq        = cneg(u_quot, dneg_r);
  assign lo2       = ($signed(lx2_r) > $signed(xp_r)) ? xp_r : lx2_r;
  assign hi2       = ($signed(lx2_r) > $signed(xp_r)) ? lx2_r : xp_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  sret_nxt = sret_r;
    a_nxt = a_r;  b_nxt = b_r;  c_nxt = c_r;
    minx_nxt = minx_r;  maxx_nxt = maxx_r;  miny_nxt = miny_r;  maxy_nxt = maxy_r;
    eq_nxt = eq_r;  ep_nxt = ep_r;
    xq_nxt = xq_r;  yq_nxt = yq_r;  xp_nxt = xp_r;  yp_nxt = yp_r;
    k_nxt = k_r;  ca_nxt = ca_r;  cb_nxt = cb_r;
    lx1_nxt = lx1_r;  rx1_nxt = rx1_r;  lx2_nxt = lx2_r;
    dneg_nxt = dneg_r;  solv_nxt = solv_r;  count_nxt = count_r;
    out_valid_nxt = out_valid_r;  out_data_nxt = out_data_r;
    uctl = '0;  u_a = '0;  u_b = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          a_nxt    = sext_field(in_tdata[31:0]);
          b_nxt    = sext_field(in_tdata[63:32]);
          c_nxt    = sext_field(in_tdata[95:64]);
          minx_nxt = sext_field(in_tdata[127:96]);
          maxx_nxt = sext_field(in_tdata[159:128]);
          miny_nxt = sext_field(in_tdata[191:160]);
          maxy_nxt = sext_field(in_tdata[223:192]);
          eq_nxt   = mag(sext_field(in_tdata[63:32]));
          ep_nxt   = mag(sext_field(in_tdata[31:0]));
          xq_nxt = '0;  yq_nxt = ONE;  xp_nxt = ONE;  yp_nxt = '0;
          count_nxt = '0;
          solv_nxt  = 1'b0;
          state_nxt = S_EU_CHK;
        end
      end
      S_WAIT: begin
        if (u_done) begin
          state_nxt = ret_r;
        end
      end
      // euclid step: q, p <- p, q mod p with bezout coefficient update
      S_EU_CHK: begin
        if (ep_r == '0) begin
          state_nxt = S_EU_END;
        end else begin
          uctl = '{start: 1'b1, op: OP_DIV, len_full: 1'b0};
          u_a = eq_r;  u_b = ep_r;
          ret_nxt = S_EU_Q;  state_nxt = S_WAIT;
        end
      end
      S_EU_Q: begin
        k_nxt = u_quot;  eq_nxt = ep_r;  ep_nxt = u_rem;
        uctl = '{start: 1'b1, op: OP_MUL, len_full: 1'b0};
        u_a = xp_r;  u_b = u_quot;
        ret_nxt = S_EU_X;  state_nxt = S_WAIT;
      end
      S_EU_X: begin
        xq_nxt = xp_r;  xp_nxt = xq_r - u_prod;
        uctl = '{start: 1'b1, op: OP_MUL, len_full: 1'b0};
        u_a = yp_r;  u_b = k_r;
        ret_nxt = S_EU_Y;  state_nxt = S_WAIT;
      end
      S_EU_Y: begin
        yq_nxt = yp_r;  yp_nxt = yq_r - u_prod;
        state_nxt = S_EU_CHK;
      end
      // solvability: gcd must divide c
      S_EU_END: begin
        if (eq_r == '0) begin
          solv_nxt = (c_r == '0);
          xq_nxt = '0;  yq_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          uctl = '{start: 1'b1, op: OP_DIV, len_full: 1'b0};
          u_a = mag(c_r);  u_b = eq_r;
          ret_nxt = S_SOLV;  state_nxt = S_WAIT;
        end
      end
      S_SOLV: begin
        if (u_rem != '0) begin
          xq_nxt = '0;  yq_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          solv_nxt = 1'b1;
          k_nxt = u_quot;
          uctl = '{start: 1'b1, op: OP_MUL, len_full: 1'b0};
          u_a = xq_r;  u_b = u_quot;
          ret_nxt = S_X0;  state_nxt = S_WAIT;
        end
      end
      S_X0: begin
        xq_nxt = cneg(u_prod, c_r[WORD_W-1] ^ a_r[WORD_W-1]);
        uctl = '{start: 1'b1, op: OP_MUL, len_full: 1'b0};
        u_a = yq_r;  u_b = k_r;
        ret_nxt = S_Y0;  state_nxt = S_WAIT;
      end
      S_Y0: begin
        yq_nxt = cneg(u_prod, c_r[WORD_W-1] ^ b_r[WORD_W-1]);
        if (degen) begin
          state_nxt = S_FIN;
        end else begin
          uctl = '{start: 1'b1, op: OP_DIV, len_full: 1'b0};
          u_a = mag(a_r);  u_b = eq_r;
          ret_nxt = S_CA;  state_nxt = S_WAIT;
        end
      end
      // reduced coefficients a/g and b/g
      S_CA: begin
        ca_nxt = cneg(u_quot, a_r[WORD_W-1]);
        uctl = '{start: 1'b1, op: OP_DIV, len_full: 1'b0};
        u_a = mag(b_r);  u_b = eq_r;
        ret_nxt = S_CB;  state_nxt = S_WAIT;
      end
      S_CB: begin
        cb_nxt = cneg(u_quot, b_r[WORD_W-1]);
        xp_nxt = xq_r;  yp_nxt = yq_r;
        state_nxt = S_B1;
      end
      // lattice step by k: x += k*B, y -= k*A
      S_ST0: begin
        uctl = '{start: 1'b1, op: OP_MUL, len_full: 1'b0};
        u_a = k_r;  u_b = mag(cb_r);
        ret_nxt = S_ST1;  state_nxt = S_WAIT;
      end
      S_ST1: begin
        xp_nxt = xp_r + cneg(u_prod, cb_r[WORD_W-1]);
        uctl = '{start: 1'b1, op: OP_MUL, len_full: 1'b0};
        u_a = k_r;  u_b = mag(ca_r);
        ret_nxt = S_ST2;  state_nxt = S_WAIT;
      end
      S_ST2: begin
        yp_nxt = yp_r - cneg(u_prod, ca_r[WORD_W-1]);
        state_nxt = sret_r;
      end
      // lower x bound
      S_B1: begin
        uctl = '{start: 1'b1, op: OP_DIV, len_full: 1'b1};
        u_a = mag(minx_r - xp_r);  u_b = mag(cb_r);
        dneg_nxt = (minx_r[WORD_W-1] ^ cb_r[WORD_W-1]) ? 1'b0 : 1'b0;
        dneg_nxt = ((minx_r - xp_r) >> (WORD_W-1)) != (cb_r >> (WORD_W-1));
        ret_nxt = S_B1K;  state_nxt = S_WAIT;
      end
      S_B1K: begin
        k_nxt = sq;  sret_nxt = S_B1C;  state_nxt = S_ST0;
      end
      S_B1C: begin
        if ($signed(xp_r) < $signed(minx_r)) begin
          k_nxt = cb_r[WORD_W-1] ? ~'0 : ONE;
          sret_nxt = S_B1D;  state_nxt = S_ST0;
        end else begin
          state_nxt = S_B1D;
        end
      end
      S_B1D: begin
        if ($signed(xp_r) > $signed(maxx_r)) begin
          state_nxt = S_FIN;
        end else begin
          lx1_nxt = xp_r;
          uctl = '{start: 1'b1, op: OP_DIV, len_full: 1'b1};
          u_a = mag(maxx_r - xp_r);  u_b = mag(cb_r);
          dneg_nxt = ((maxx_r - xp_r) >> (WORD_W-1)) != (cb_r >> (WORD_W-1));
          ret_nxt = S_B2K;  state_nxt = S_WAIT;
        end
      end
      // upper x bound
      S_B2K: begin
        k_nxt = sq;  sret_nxt = S_B2C;  state_nxt = S_ST0;
      end
      S_B2C: begin
        if ($signed(xp_r) > $signed(maxx_r)) begin
          k_nxt = cb_r[WORD_W-1] ? ONE : ~'0;
          sret_nxt = S_B2D;  state_nxt = S_ST0;
        end else begin
          state_nxt = S_B2D;
        end
      end
      S_B2D: begin
        rx1_nxt = xp_r;
        uctl = '{start: 1'b1, op: OP_DIV, len_full: 1'b1};
        u_a = mag(yp_r - miny_r);  u_b = mag(ca_r);
        dneg_nxt = ((yp_r - miny_r) >> (WORD_W-1)) != (ca_r >> (WORD_W-1));
        ret_nxt = S_B3K;  state_nxt = S_WAIT;
      end
      // lower y bound
      S_B3K: begin
        k_nxt = sq;  sret_nxt = S_B3C;  state_nxt = S_ST0;
      end
      S_B3C: begin
        if ($signed(yp_r) < $signed(miny_r)) begin
          k_nxt = ca_r[WORD_W-1] ? ONE : ~'0;
          sret_nxt = S_B3D;  state_nxt = S_ST0;
        end else begin
          state_nxt = S_B3D;
        end
      end
      S_B3D: begin
        if ($signed(yp_r) > $signed(maxy_r)) begin
          state_nxt = S_FIN;
        end else begin
          lx2_nxt = xp_r;
          uctl = '{start: 1'b1, op: OP_DIV, len_full: 1'b1};
          u_a = mag(yp_r - maxy_r);  u_b = mag(ca_r);
          dneg_nxt = ((yp_r - maxy_r) >> (WORD_W-1)) != (ca_r >> (WORD_W-1));
          ret_nxt = S_B4K;  state_nxt = S_WAIT;
        end
      end
      // upper y bound
      S_B4K: begin
        k_nxt = sq;  sret_nxt = S_B4C;  state_nxt = S_ST0;
      end
      S_B4C: begin
        if ($signed(yp_r) > $signed(maxy_r)) begin
          k_nxt = ca_r[WORD_W-1] ? ~'0 : ONE;
          sret_nxt = S_B4D;  state_nxt = S_ST0;
        end else begin
          state_nxt = S_B4D;
        end
      end
      // intersect the two x intervals
      S_B4D: begin
        lx1_nxt = ($signed(lx1_r) > $signed(lo2)) ? lx1_r : lo2;
        rx1_nxt = ($signed(rx1_r) < $signed(hi2)) ? rx1_r : hi2;
        state_nxt = S_B5;
      end
      S_B5: begin
        if ($signed(lx1_r) > $signed(rx1_r)) begin
          state_nxt = S_FIN;
        end else begin
          uctl = '{start: 1'b1, op: OP_DIV, len_full: 1'b1};
          u_a = rx1_r - lx1_r;  u_b = mag(cb_r);
          ret_nxt = S_CNT;  state_nxt = S_WAIT;
        end
      end
      S_CNT: begin
        count_nxt = u_quot[CNT_W-1:0] + {{(CNT_W-1){1'b0}}, 1'b1};
        state_nxt = S_FIN;
      end
      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, eq_r[FIELD_W-1:0], yq_r, xq_r, degen, solv_r,
                           count_r};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ret_r <= ret_nxt;  sret_r <= sret_nxt;
    a_r <= a_nxt;  b_r <= b_nxt;  c_r <= c_nxt;
    minx_r <= minx_nxt;  maxx_r <= maxx_nxt;  miny_r <= miny_nxt;  maxy_r <= maxy_nxt;
    eq_r <= eq_nxt;  ep_r <= ep_nxt;
    xq_r <= xq_nxt;  yq_r <= yq_nxt;  xp_r <= xp_nxt;  yp_r <= yp_nxt;
    k_r <= k_nxt;  ca_r <= ca_nxt;  cb_r <= cb_nxt;
    lx1_r <= lx1_nxt;  rx1_r <= rx1_nxt;  lx2_r <= lx2_nxt;
    dneg_r <= dneg_nxt;  solv_r <= solv_nxt;  count_r <= count_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sv/dsc_iter_unit.sv
// shared iterative unit: restoring unsigned divide or shift-add multiply, one bit a cycle
// depends on dsc_pkg; both operations run through one 64-bit adder
module dsc_iter_unit import dsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dsc_ctl_t          ctl,
  input  logic [WORD_W-1:0] opa,     // dividend or multiplicand
  input  logic [WORD_W-1:0] opb,     // divisor or multiplier
  output logic              done,
  output logic [WORD_W-1:0] quot,
  output logic [WORD_W-1:0] rem,
  output logic [WORD_W-1:0] prod
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              op_r, op_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] sh_r, sh_nxt;
  logic [WORD_W-1:0] mp_r, mp_nxt;
  logic [WORD_W-1:0] den_r, den_nxt;

  logic [WORD_W-1:0] trial;
  logic [WORD_W-1:0] add_a, add_b;
  logic              add_cin;
  logic [WORD_W:0]   sum;

  // shared adder: subtract for divide, add for multiply
  always_comb begin
    trial   = {acc_r[WORD_W-2:0], sh_r[WORD_W-1]};
    add_a   = (op_r == OP_DIV) ? trial : acc_r;
    add_b   = (op_r == OP_DIV) ? ~den_r : sh_r;
    add_cin = (op_r == OP_DIV);
    sum     = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_cin};
  end

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mp_nxt   = mp_r;
    den_nxt  = den_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      cnt_nxt  = ctl.len_full ? 7'd64 : 7'd32;
      acc_nxt  = '0;
      den_nxt  = opb;
      if (ctl.op == OP_DIV) begin
        sh_nxt = ctl.len_full ? opa : {opa[WORD_W/2-1:0], {(WORD_W/2){1'b0}}};
        mp_nxt = '0;
      end else begin
        sh_nxt = opa;
        mp_nxt = opb;
      end
    end else if (busy_r) begin
      if (op_r == OP_DIV) begin
        acc_nxt = sum[WORD_W] ? sum[WORD_W-1:0] : trial;
        mp_nxt  = {mp_r[WORD_W-2:0], sum[WORD_W]};
      end else begin
        if (mp_r[0]) begin
          acc_nxt = sum[WORD_W-1:0];
        end
        mp_nxt = {1'b0, mp_r[WORD_W-1:1]};
      end
      sh_nxt  = {sh_r[WORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mp_r  <= mp_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = mp_r;
  assign rem  = acc_r;
  assign prod = acc_r;

endmodule

FILE: sv/dsc_checker.sv
// port-level checks for the diophantine solution counter
// depends on dsc_pkg; bound to the top level below
module dsc_checker import dsc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // the block is busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // degenerate equations give no solutions
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> out_tdata[32:0] == '0)
    else $error("degenerate result with nonzero count");

  // unsolvable equations give zero count and zero particular solution
  a_unsolv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[33] |->
      out_tdata[32:0] == '0 && out_tdata[162:35] == '0)
    else $error("unsolvable result carries data");

  // reset drops the result channel
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind diophantine_solution_counter dsc_checker u_dsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: dv/diophantine_result_checker.sv
// result checker for the diophantine solution counter: watches both streams,
// predicts each result from the accepted input and compares field by field
// depends on dsc_pkg for the stream widths
`timescale 1ns / 100ps

module diophantine_result_checker import dsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               results_pending
);

  typedef struct packed {
    logic [31:0] gcd_value;
    logic [63:0] any_y;
    logic [63:0] any_x;
    logic        degenerate;
    logic        solvable;
    logic [32:0] solution_count;
  } solution_t;

  solution_t expected_results[$];
  int        mismatches = 0;

  assign fail_count      = mismatches;
  assign results_pending = expected_results.size();

  function automatic longint unsigned magnitude(input longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  // division truncating toward zero, zero divisor gives zero
  function automatic longint trunc_div(input longint n, input longint d);
    longint unsigned q;
    if (d == 0) return 0;
    q = magnitude(n) / magnitude(d);
    return ((n < 0) != (d < 0)) ? longint'(64'd0 - q) : longint'(q);
  endfunction

  // extended euclid on non-negative operands: p*bx + q*by = gcd
  function automatic longint unsigned euclid_gcd(input longint unsigned p,
                                                 input longint unsigned q,
                                                 output longint bx, output longint by);
    longint unsigned quo[64];
    longint unsigned r;
    longint          x, y, t;
    int              n;
    n = 0;
    x = 0;
    y = 1;
    while (p != 0 && n < 64) begin
      r = q % p;
      quo[n] = q / p;
      n++;
      q = p;
      p = r;
    end
    while (n > 0) begin
      n--;
      t = x;
      x = y - longint'(quo[n]) * x;
      y = t;
    end
    bx = x;
    by = y;
    return q;
  endfunction

  // walk the lattice (x + k*b, y - k*a) to the x range meeting both bounds
  function automatic longint unsigned box_solution_count(
      input longint a, input longint b, input longint x, input longint y,
      input longint minx, input longint maxx, input longint miny, input longint maxy);
    longint sa, sb, k, lx1, rx1, lx2, rx2, lx, rx, t;
    sa = a > 0 ? 1 : -1;
    sb = b > 0 ? 1 : -1;
    k = trunc_div(minx - x, b);
    x = x + k * b; y = y - k * a;
    if (x < minx) begin
      x = x + sb * b; y = y - sb * a;
    end
    if (x > maxx) return 0;
    lx1 = x;
    k = trunc_div(maxx - x, b);
    x = x + k * b; y = y - k * a;
    if (x > maxx) begin
      x = x - sb * b; y = y + sb * a;
    end
    rx1 = x;
    k = trunc_div(-(miny - y), a);
    x = x + k * b; y = y - k * a;
    if (y < miny) begin
      x = x - sa * b; y = y + sa * a;
    end
    if (y > maxy) return 0;
    lx2 = x;
    k = trunc_div(-(maxy - y), a);
    x = x + k * b; y = y - k * a;
    if (y > maxy) begin
      x = x + sa * b; y = y - sa * a;
    end
    rx2 = x;
    if (lx2 > rx2) begin
      t = lx2; lx2 = rx2; rx2 = t;
    end
    lx = lx1 > lx2 ? lx1 : lx2;
    rx = rx1 < rx2 ? rx1 : rx2;
    if (lx > rx) return 0;
    return (unsigned'(rx) - unsigned'(lx)) / magnitude(b) + 1;
  endfunction

  function automatic solution_t solve_equation(input logic [IN_W-1:0] item);
    solution_t       res;
    longint          a, b, c, minx, maxx, miny, maxy, x0, y0, g, k;
    longint unsigned gu, cnt;
    logic            solv, degen;
    a    = longint'(signed'(item[31:0]));
    b    = longint'(signed'(item[63:32]));
    c    = longint'(signed'(item[95:64]));
    minx = longint'(signed'(item[127:96]));
    maxx = longint'(signed'(item[159:128]));
    miny = longint'(signed'(item[191:160]));
    maxy = longint'(signed'(item[223:192]));
    cnt   = 0;
    degen = (a == 0 || b == 0);
    gu = euclid_gcd(magnitude(a), magnitude(b), x0, y0);
    g  = longint'(gu);
    if (gu == 0) begin
      solv = (c == 0);
      x0 = 0;
      y0 = 0;
    end else begin
      solv = (magnitude(c) % gu) == 0;
      if (solv) begin
        k  = trunc_div(c, g);
        x0 = x0 * k;
        y0 = y0 * k;
        if (a < 0) x0 = -x0;
        if (b < 0) y0 = -y0;
        if (!degen)
          cnt = box_solution_count(trunc_div(a, g), trunc_div(b, g), x0, y0,
                                   minx, maxx, miny, maxy);
      end else begin
        x0 = 0;
        y0 = 0;
      end
    end
    res.solution_count = cnt[32:0];
    res.solvable       = solv;
    res.degenerate     = degen;
    res.any_x          = x0;
    res.any_y          = y0;
    res.gcd_value      = gu[31:0];
    return res;
  endfunction

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    solution_t exp_r, got;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_results.push_back(solve_equation(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(solution_t)-1:0];
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transaction %h", $time, out_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.solution_count !== exp_r.solution_count) begin
            mismatches++;
            $display("%0t: solution_count expected %0d actual %0d", $time,
                     exp_r.solution_count, got.solution_count);
          end
          if (got.solvable !== exp_r.solvable) begin
            mismatches++;
            $display("%0t: solvable expected %b actual %b", $time,
                     exp_r.solvable, got.solvable);
          end
          if (got.degenerate !== exp_r.degenerate) begin
            mismatches++;
            $display("%0t: degenerate expected %b actual %b", $time,
                     exp_r.degenerate, got.degenerate);
          end
          if (got.any_x !== exp_r.any_x) begin
            mismatches++;
            $display("%0t: any_x expected %0d actual %0d", $time,
                     signed'(exp_r.any_x), signed'(got.any_x));
          end
          if (got.any_y !== exp_r.any_y) begin
            mismatches++;
            $display("%0t: any_y expected %0d actual %0d", $time,
                     signed'(exp_r.any_y), signed'(got.any_y));
          end
          if (got.gcd_value !== exp_r.gcd_value) begin
            mismatches++;
            $display("%0t: gcd_value expected %0d actual %0d", $time,
                     exp_r.gcd_value, got.gcd_value);
          end
        end
      end
    end
  end

endmodule

FILE: dv/diophantine_solution_counter_test.sv
// top of the diophantine solution counter test: clock, reset, stimulus and verdict
// depends on dsc_pkg, the counter rtl and diophantine_result_checker
`timescale 1ns / 100ps

module diophantine_solution_counter_test;
  import dsc_pkg::*;

  localparam int MAX_I = 32'sh7fffffff;
  localparam int MIN_I = 32'sh80000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  int               fail_count;
  int               results_pending;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  always #5 clk = ~clk;

  diophantine_solution_counter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  diophantine_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .results_pending(results_pending)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transaction; valid stays up between back-to-back items
  task automatic send_equation(input int a, input int b, input int c,
                               input int xl, input int xu, input int yl, input int yu);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yu, yl, xu, xl, c, b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly well-formed equations with a known solution, some noise and edges
  task automatic send_random;
    int a, b, x0, y0, span, pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      a = $urandom_range(60) - 30;
      b = $urandom_range(60) - 30;
      if (a == 0) a = 7;
      if (b == 0) b = -5;
      x0 = $urandom_range(200) - 100;
      y0 = $urandom_range(200) - 100;
      span = $urandom_range(400);
      send_equation(a, b, a * x0 + b * y0, x0 - $urandom_range(span), x0 + $urandom_range(span),
                    y0 - $urandom_range(span), y0 + $urandom_range(span));
    end else if (pick < 85) begin
      send_equation($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      a = ($urandom_range(3) == 0) ? 0 : $urandom_range(1000) - 500;
      b = ($urandom_range(3) == 0) ? 0 : $urandom;
      send_equation(a, b, $urandom_range(3) == 0 ? 0 : $urandom_range(2000) - 1000,
                    MIN_I, MAX_I, $urandom_range(1) ? MIN_I : 0, MAX_I);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero coefficients, unsolvable, empty box, signs
    send_equation(3, 5, 7, -100, 100, -100, 100);
    send_equation(-3, 5, 7, -100, 100, -100, 100);
    send_equation(3, -5, -7, -100, 100, -100, 100);
    send_equation(-3, -5, 7, -100, 100, -100, 100);
    send_equation(4, 6, 7, -100, 100, -100, 100);
    send_equation(0, 6, 12, -10, 10, -10, 10);
    send_equation(6, 0, 12, -10, 10, -10, 10);
    send_equation(0, 0, 0, -10, 10, -10, 10);
    send_equation(0, 0, 5, -10, 10, -10, 10);
    send_equation(2, 3, 12, 10, -10, -10, 10);
    send_equation(2, 3, 12, -10, 10, 10, -10);
    send_equation(1, 1, 0, MIN_I, MAX_I, MIN_I, MAX_I);
    send_equation(1, -1, 0, MIN_I, MAX_I, MIN_I, MAX_I);
    send_equation(MIN_I, MIN_I, MIN_I, MIN_I, MAX_I, MIN_I, MAX_I);
    send_equation(MAX_I, MAX_I - 1, MAX_I, MIN_I, MAX_I, MIN_I, MAX_I);
    send_equation(MIN_I, MAX_I, 1, MIN_I, MAX_I, MIN_I, MAX_I);
    send_equation(MAX_I, MIN_I, -1, 0, 0, 0, 0);
    send_equation(1836311903, 1134903170, MAX_I, MIN_I, MAX_I, MIN_I, MAX_I);
    send_equation(-1, 1, MIN_I, MIN_I, MAX_I, MIN_I, MAX_I);
    send_equation(7, 7, 14, 1, 1, 1, 1);

    // random phases with different idling
    for (int i = 0; i < 300; i++) begin
      case (i / 75)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      send_random();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain, then allow the block's latency before the verdict
    while (results_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
